/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the frame fault injector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define FFI_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define FFI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define FFI_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define FFI_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* rtl/core/ffi_pkg.sv */
// Shared types, codes and constants of the frame fault injector.
package ffi_pkg;

    localparam int TAIL_DEPTH_DEF = 16;
    // Holds any emit count up to the largest supported tail depth (1024).
    localparam int CNT_MAX_W      = 11;
    localparam int Q_DEPTH        = 4;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 17;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_ARM  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION,
        REG_TRIGGER,
        REG_THRESHOLD,
        REG_EVERY_NTH,
        REG_FAULT_KIND,
        REG_TAIL_COUNT,
        REG_XOR_MASK,
        REG_KEEP_BYTES
    } cfg_reg_t;

    localparam logic [1:0] DIR_OFF  = 2'd0;
    localparam logic [1:0] DIR_IN   = 2'd1;
    localparam logic [1:0] DIR_OUT  = 2'd2;
    localparam logic [1:0] DIR_BOTH = 2'd3;

    localparam logic [1:0] TRIG_ALWAYS = 2'd0;
    localparam logic [1:0] TRIG_RANDOM = 2'd1;
    localparam logic [1:0] TRIG_NTH    = 2'd2;
    localparam logic [1:0] TRIG_MANUAL = 2'd3;

    localparam logic [1:0] KIND_DROP  = 2'd0;
    localparam logic [1:0] KIND_XOR   = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  direction_mode;
        logic [1:0]  trigger_mode;
        logic [16:0] fire_threshold;
        logic [16:0] every_nth;
        logic [1:0]  fault_kind;
        logic [4:0]  tail_count;
        logic [7:0]  xor_mask;
        logic [10:0] keep_bytes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        direction_mode: DIR_OUT,
        trigger_mode:   TRIG_RANDOM,
        fire_threshold: 17'h10000,
        every_nth:      17'd2,
        fault_kind:     KIND_DROP,
        tail_count:     5'd2,
        xor_mask:       8'hFF,
        keep_bytes:     11'd0
    };

    typedef enum logic [2:0] {
        OP_PASS,
        OP_DROP_END,
        OP_FILL,
        OP_SHIFT,
        OP_FLUSH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        logic [7:0]             data;
        logic                   last;
        logic [CNT_MAX_W-1:0]   emit;
        logic                   inject;
        logic                   xor_en;
        logic [31:0]            eval_cnt;
        logic [31:0]            act_cnt;
    } cmd_t;

endpackage

/* rtl/core/ffi_ifs.sv */
// Handshake interfaces of the frame fault injector: input items, results, configuration.
interface ffi_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  data_byte;
    logic        frame_last;
    logic        arrival_inbound;
    logic [15:0] random_value;

    modport source (output valid, func, data_byte, frame_last, arrival_inbound, random_value,
                    input ready);
    modport sink   (input valid, func, data_byte, frame_last, arrival_inbound, random_value,
                    output ready);
endinterface

interface ffi_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        frame_end;
    logic        fault_injected;
    logic [31:0] evaluation_count;
    logic [31:0] activation_count;

    modport source (output valid, out_byte, byte_valid, frame_end, fault_injected,
                    evaluation_count, activation_count, input ready);
    modport sink   (input valid, out_byte, byte_valid, frame_end, fault_injected,
                    evaluation_count, activation_count, output ready);
endinterface

interface ffi_cfg_if;
    import ffi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ffi_cmd_fifo.sv */
// Short command queue between the classifying front and the tail-handling back.
module ffi_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ffi_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ffi_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import ffi_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    cmd_t          slot_mem [Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full  = (count_reg == (AW + 1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/ffi_front.sv */
// Front unit: configuration registers, frame tracking, fire decision and command generation.
module ffi_front #(
    parameter int TAIL_DEPTH = ffi_pkg::TAIL_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ffi_item_if.sink      items,
    ffi_cfg_if.sink       cfg,
    input  logic          q_full,
    output logic          q_push,
    output ffi_pkg::cmd_t q_cmd,
    output logic [7:0]    xor_mask
);
    import ffi_pkg::*;

    localparam int CNT_W = $clog2(TAIL_DEPTH + 1);

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_hit;

    logic             armed_reg, armed_next;
    logic [16:0]      phase_reg, phase_next;
    logic [31:0]      eval_reg, eval_next;
    logic [31:0]      act_reg, act_next;
    logic             in_frame_reg, in_frame_next;
    logic             fires_reg, fires_next;
    logic             was_armed_reg, was_armed_next;
    logic [15:0]      len_reg, len_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] width_reg, width_next;

    logic             accept, is_arm, data_acc, first, dir_ok, dir_hit;
    logic [16:0]      phase_inc, nth_div, phase_new, tc_ext, width_cfg17;
    logic             nth_hit, trig_fire;
    logic [CNT_W-1:0] width_cfg, width_cur, fill_cur, cap, tn;
    logic [1:0]       kind_cur;
    logic             fires_cur, was_armed_cur;
    logic [15:0]      len_cur;
    logic [31:0]      eval_cur;
    logic             push, close, inj;
    logic signed [17:0] len_s, wid_s, keep_s, tn_s, ns_s, e_s;

    assign items.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign xor_mask    = cfg_reg.xor_mask;

    // Register writes; an index beyond the list changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg.valid)
        begin
            cfg_hit = 1'b1;
            case (cfg.index)
                REG_DIRECTION:  cfg_next.direction_mode = cfg.data[1:0];
                REG_TRIGGER:    cfg_next.trigger_mode   = cfg.data[1:0];
                REG_THRESHOLD:  cfg_next.fire_threshold = cfg.data[16:0];
                REG_EVERY_NTH:  cfg_next.every_nth      = cfg.data[16:0];
                REG_FAULT_KIND: cfg_next.fault_kind     = cfg.data[1:0];
                REG_TAIL_COUNT: cfg_next.tail_count     = cfg.data[4:0];
                REG_XOR_MASK:   cfg_next.xor_mask       = cfg.data[7:0];
                REG_KEEP_BYTES: cfg_next.keep_bytes     = cfg.data[10:0];
                default:        cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        accept   = items.valid && items.ready;
        is_arm   = (items.func == FUNC_ARM);
        data_acc = accept && !is_arm;
        first    = !in_frame_reg;

        case (cfg_reg.direction_mode)
            DIR_BOTH: dir_ok = 1'b1;
            DIR_IN:   dir_ok = items.arrival_inbound;
            DIR_OUT:  dir_ok = !items.arrival_inbound;
            default:  dir_ok = 1'b0;
        endcase
        dir_hit = first && dir_ok;

        phase_inc = phase_reg + 17'd1;
        nth_div   = (cfg_reg.every_nth == '0) ? 17'd1 : cfg_reg.every_nth;
        nth_hit   = (phase_inc >= nth_div);
        phase_new = nth_hit ? '0 : phase_inc;

        case (cfg_reg.trigger_mode)
            TRIG_ALWAYS: trig_fire = 1'b1;
            TRIG_NTH:    trig_fire = nth_hit;
            TRIG_MANUAL: trig_fire = 1'b0;
            default:     trig_fire = ({1'b0, items.random_value} < cfg_reg.fire_threshold);
        endcase

        // Tail width: zero counts as one, large values saturate to the ring depth.
        tc_ext      = 17'(cfg_reg.tail_count);
        width_cfg17 = (tc_ext == '0) ? 17'd1 :
                      ((tc_ext > 17'(TAIL_DEPTH)) ? 17'(TAIL_DEPTH) : tc_ext);
        width_cfg   = width_cfg17[CNT_W-1:0];

        kind_cur      = first ? cfg_reg.fault_kind : kind_reg;
        width_cur     = first ? width_cfg : width_reg;
        fires_cur     = first ? (dir_hit && (armed_reg || trig_fire)) : fires_reg;
        was_armed_cur = first ? (dir_hit && armed_reg) : was_armed_reg;
        fill_cur      = first ? '0 : fill_reg;
        len_cur       = first ? 16'd1 : ((len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1);
        eval_cur      = eval_reg + {31'd0, dir_hit};

        cap = width_cur - CNT_W'(1);
        tn  = fill_cur + CNT_W'(1);

        len_s  = $signed(18'(len_cur));
        wid_s  = $signed(18'(width_cur));
        keep_s = $signed(18'(cfg_reg.keep_bytes));
        tn_s   = $signed(18'(tn));
        ns_s   = len_s - wid_s;
        if (ns_s < keep_s)
        begin
            ns_s = keep_s;
        end
        e_s = ns_s - len_s + tn_s;
        if (e_s < 18'sd0)
        begin
            e_s = 18'sd0;
        end
        if (e_s > tn_s)
        begin
            e_s = tn_s;
        end

        push      = 1'b0;
        close     = 1'b0;
        inj       = 1'b0;
        fill_next = fill_cur;

        q_cmd.op       = OP_PASS;
        q_cmd.data     = items.data_byte;
        q_cmd.last     = items.frame_last;
        q_cmd.emit     = CNT_MAX_W'(tn);
        q_cmd.inject   = 1'b0;
        q_cmd.xor_en   = 1'b0;
        q_cmd.eval_cnt = eval_cur;

        if (!fires_cur || (kind_cur == KIND_NONE))
        begin
            push  = 1'b1;
            close = items.frame_last;
        end
        else if (kind_cur == KIND_DROP)
        begin
            if (items.frame_last)
            begin
                q_cmd.op = OP_DROP_END;
                push     = 1'b1;
                close    = 1'b1;
                inj      = 1'b1;
            end
        end
        else if (!items.frame_last)
        begin
            push = 1'b1;
            if (cap == '0)
            begin
                q_cmd.op = OP_PASS;
            end
            else if (fill_cur >= cap)
            begin
                q_cmd.op = OP_SHIFT;
            end
            else
            begin
                q_cmd.op  = OP_FILL;
                fill_next = fill_cur + CNT_W'(1);
            end
        end
        else
        begin
            q_cmd.op = OP_FLUSH;
            push     = 1'b1;
            close    = 1'b1;
            if (kind_cur == KIND_XOR)
            begin
                inj          = (len_cur >= 16'(width_cur));
                q_cmd.xor_en = inj;
            end
            else
            begin
                inj = (len_cur > 16'(cfg_reg.keep_bytes));
                if (inj)
                begin
                    q_cmd.emit = e_s[CNT_MAX_W-1:0];
                end
            end
        end
        q_cmd.inject = inj;

        act_next      = act_reg + {31'd0, (data_acc && close && inj)};
        q_cmd.act_cnt = act_next;
        q_push        = data_acc && push;

        // A pending arm is consumed by a matching frame and given back if its fault declines.
        armed_next = armed_reg;
        if (data_acc && dir_hit)
        begin
            armed_next = 1'b0;
        end
        if (data_acc && close && !inj && was_armed_cur)
        begin
            armed_next = 1'b1;
        end
        if (accept && is_arm)
        begin
            armed_next = 1'b1;
        end

        phase_next = phase_reg;
        if (cfg_hit)
        begin
            phase_next = '0;
        end
        else if (data_acc && dir_hit)
        begin
            phase_next = phase_new;
        end

        eval_next      = data_acc ? eval_cur : eval_reg;
        in_frame_next  = data_acc ? !items.frame_last : in_frame_reg;
        fires_next     = data_acc ? fires_cur : fires_reg;
        was_armed_next = data_acc ? was_armed_cur : was_armed_reg;
        len_next       = data_acc ? len_cur : len_reg;
        kind_next      = data_acc ? kind_cur : kind_reg;
        width_next     = data_acc ? width_cur : width_reg;
        if (!data_acc)
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            armed_reg     <= 1'b0;
            phase_reg     <= '0;
            eval_reg      <= '0;
            act_reg       <= '0;
            in_frame_reg  <= 1'b0;
            fires_reg     <= 1'b0;
            was_armed_reg <= 1'b0;
            len_reg       <= '0;
            fill_reg      <= '0;
            kind_reg      <= KIND_DROP;
            width_reg     <= CNT_W'(1);
        end
        else
        begin
            cfg_reg       <= cfg_next;
            armed_reg     <= armed_next;
            phase_reg     <= phase_next;
            eval_reg      <= eval_next;
            act_reg       <= act_next;
            in_frame_reg  <= in_frame_next;
            fires_reg     <= fires_next;
            was_armed_reg <= was_armed_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            kind_reg      <= kind_next;
            width_reg     <= width_next;
        end
    end

endmodule

/* rtl/core/ffi_back.sv */
// Back unit: tail delay ring, frame-end release and the registered result stage.
module ffi_back #(
    parameter int TAIL_DEPTH = ffi_pkg::TAIL_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffi_pkg::cmd_t q_head,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic [7:0]    xor_mask,
    ffi_result_if.source  results
);
    import ffi_pkg::*;

    localparam int CNT_W = $clog2(TAIL_DEPTH + 1);
    localparam int PTR_W = $clog2(TAIL_DEPTH);

    typedef enum logic [3:0] {
        BK_IDLE      = 4'b0001,
        BK_SHIFT     = 4'b0010,
        BK_FLUSH_RD  = 4'b0100,
        BK_FLUSH_OUT = 4'b1000
    } bk_state_t;

    bk_state_t        state_reg, state_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    cmd_t             cur_reg, cur_next;

    logic [7:0]       ring_mem [TAIL_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_we;

    logic             res_valid_reg, res_valid_next;
    logic [7:0]       res_byte_reg;
    logic             res_bv_reg, res_end_reg, res_fi_reg;
    logic [31:0]      res_eval_reg, res_act_reg;

    logic             load_ok, load;
    logic [7:0]       ld_byte;
    logic             ld_bv, ld_end, ld_fi;
    logic [31:0]      ld_eval, ld_act;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(TAIL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign load_ok = !res_valid_reg || results.ready;

    always_comb
    begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        rem_next    = rem_reg;
        cur_next    = cur_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        load        = 1'b0;
        ld_byte     = 8'h00;
        ld_bv       = 1'b0;
        ld_end      = 1'b0;
        ld_fi       = 1'b0;
        ld_eval     = cur_reg.eval_cnt;
        ld_act      = cur_reg.act_cnt;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.op)
                        OP_PASS:
                        begin
                            if (load_ok)
                            begin
                                load    = 1'b1;
                                ld_byte = q_head.data;
                                ld_bv   = 1'b1;
                                ld_end  = q_head.last;
                                ld_eval = q_head.eval_cnt;
                                ld_act  = q_head.act_cnt;
                                q_pop   = 1'b1;
                            end
                        end
                        OP_DROP_END:
                        begin
                            if (load_ok)
                            begin
                                load    = 1'b1;
                                ld_end  = 1'b1;
                                ld_fi   = 1'b1;
                                ld_eval = q_head.eval_cnt;
                                ld_act  = q_head.act_cnt;
                                q_pop   = 1'b1;
                            end
                        end
                        OP_FILL:
                        begin
                            q_pop       = 1'b1;
                            mem_we      = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                        end
                        OP_SHIFT:
                        begin
                            // The write lands after the newest entry; the oldest entry is read this cycle.
                            q_pop       = 1'b1;
                            mem_we      = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            cur_next    = q_head;
                            state_next  = BK_SHIFT;
                        end
                        OP_FLUSH:
                        begin
                            q_pop       = 1'b1;
                            mem_we      = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            cur_next    = q_head;
                            rem_next    = q_head.emit[CNT_W-1:0];
                            state_next  = BK_FLUSH_RD;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SHIFT:
            begin
                if (load_ok)
                begin
                    load        = 1'b1;
                    ld_byte     = rd_data_reg;
                    ld_bv       = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    state_next  = BK_IDLE;
                end
            end
            BK_FLUSH_RD:
            begin
                // A wait state so that the last byte's write is visible to the ring read.
                state_next = BK_FLUSH_OUT;
            end
            BK_FLUSH_OUT:
            begin
                if (load_ok)
                begin
                    load = 1'b1;
                    if (rem_reg == '0)
                    begin
                        ld_end      = 1'b1;
                        ld_fi       = cur_reg.inject;
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = BK_IDLE;
                    end
                    else
                    begin
                        ld_byte  = rd_data_reg ^ (cur_reg.xor_en ? xor_mask : 8'h00);
                        ld_bv    = 1'b1;
                        ld_end   = (rem_reg == CNT_W'(1));
                        ld_fi    = (rem_reg == CNT_W'(1)) && cur_reg.inject;
                        rem_next = rem_reg - CNT_W'(1);
                        if (rem_reg == CNT_W'(1))
                        begin
                            // Bytes cut by truncation are discarded with the rest of the ring.
                            rd_ptr_next = wr_ptr_reg;
                            state_next  = BK_IDLE;
                        end
                        else
                        begin
                            rd_ptr_next = ptr_inc(rd_ptr_reg);
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_valid_next = res_valid_reg && !results.ready;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            res_byte_reg <= ld_byte;
            res_bv_reg   <= ld_bv;
            res_end_reg  <= ld_end;
            res_fi_reg   <= ld_fi;
            res_eval_reg <= ld_eval;
            res_act_reg  <= ld_act;
        end
    end

    // Tail ring: one write port, one registered read port that follows the read pointer.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_ptr_reg] <= q_head.data;
        end
        rd_data_reg <= ring_mem[rd_ptr_next];
    end

    assign results.valid            = res_valid_reg;
    assign results.out_byte         = res_byte_reg;
    assign results.byte_valid       = res_bv_reg;
    assign results.frame_end        = res_end_reg;
    assign results.fault_injected   = res_fi_reg;
    assign results.evaluation_count = res_eval_reg;
    assign results.activation_count = res_act_reg;

endmodule

/* rtl/core/frame_fault_injector_core.sv */
// Top level of the frame fault injector: front, command queue and back unit.
//
//  Channel   Direction  Handshake     Carries
//  items     in         valid/ready   func, data_byte, frame_last, arrival_inbound, random_value
//  results   out        valid/ready   out_byte, byte_valid, frame_end, fault_injected, counts
//  cfg       in         valid/ready   index, data (one register write per item)
//
// Passed-through and buffered bytes are handled in the idle state; a byte that pushes out the oldest
// tail byte also passes the shift state, for the registered read of the tail ring.
// A frame end that releases the tail goes through the flush read and flush output states,
// then emits its N bytes, or one empty result to mark the frame end when no byte is left.
// The four-entry command queue lets the front keep accepting while the back drains.
// Reset is asynchronous and needs no clearing pass; the tail ring is only read where written.
// A low results.ready holds the output register; items.ready drops while the queue is full.
`include "assert_macros.svh"

module frame_fault_injector_core #(
    parameter int TAIL_DEPTH = ffi_pkg::TAIL_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ffi_item_if.sink     items,
    ffi_result_if.source results,
    ffi_cfg_if.sink      cfg
);
    import ffi_pkg::*;

    cmd_t       q_cmd;
    cmd_t       q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic [7:0] xor_mask;
    logic       arm_taken;
    logic       empty_result;
    logic       empty_ok;

    ffi_front #(
        .TAIL_DEPTH (TAIL_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .xor_mask (xor_mask)
    );

    ffi_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ffi_back #(
        .TAIL_DEPTH (TAIL_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .xor_mask (xor_mask),
        .results  (results)
    );

    assign arm_taken    = items.valid && items.ready && (items.func == FUNC_ARM);
    assign empty_result = results.valid && !results.byte_valid;
    assign empty_ok     = results.frame_end && (results.out_byte == 8'h00);

    `FFI_ASSERT_IMPL(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
    `FFI_ASSERT_IMPL(a_queue_no_underflow, clk, rst_n, q_pop, !q_empty)
    `FFI_ASSERT_IMPL(a_arm_makes_no_command, clk, rst_n, arm_taken, !q_push)
    `FFI_ASSERT_IMPL(a_empty_result_ends_frame, clk, rst_n, empty_result, empty_ok)

endmodule
